### design/crcbs_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 byte stream checker package
// Widths, reset values and the internal item type shared by the checker.
// ----------------------------------------------------------------------------
package crcbs_pkg;

    localparam int CRC_W  = 16;
    localparam int DATA_W = 8;

    // Generator polynomial without its top bit
    localparam logic [CRC_W-1:0] POLY_RESET = 16'hA097;

    // Input item as held in the input register
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
        logic [CRC_W-1:0]  check_crc;
    } item_t;

endpackage

### design/crcbs_if.sv
// ----------------------------------------------------------------------------
// CRC-16 byte stream checker channels
// Valid/ready channels for message bytes, results and polynomial writes.
// ----------------------------------------------------------------------------
interface crcbs_msg_if;
    logic                        valid;
    logic                        ready;
    logic [crcbs_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;
    logic [crcbs_pkg::CRC_W-1:0]  check_crc;

    modport source (output valid, output data_byte, output last_byte,
                    output check_crc, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input check_crc, output ready);
endinterface

interface crcbs_result_if;
    logic                       valid;
    logic                       ready;
    logic [crcbs_pkg::CRC_W-1:0] crc_value;
    logic                       crc_match;

    modport source (output valid, output crc_value, output crc_match, input ready);
    modport sink   (input valid, input crc_value, input crc_match, output ready);
endinterface

interface crcbs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [crcbs_pkg::CRC_W-1:0] polynomial;

    modport source (output valid, output polynomial, input ready);
    modport sink   (input valid, input polynomial, output ready);
endinterface

### design/crcbs_in_reg.sv
// ----------------------------------------------------------------------------
// CRC-16 checker input register
// Holds one message byte until the datapath consumes it.
// ----------------------------------------------------------------------------
module crcbs_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    crcbs_msg_if.sink            msg,
    input  logic                 advance,
    output crcbs_pkg::item_t     item
);

    crcbs_pkg::item_t item_reg;
    crcbs_pkg::item_t item_next;
    logic             load;

    assign msg.ready = !item_reg.valid || advance;
    assign load      = msg.valid && msg.ready;

    always_comb
    begin
        item_next = item_reg;
        if (load)
        begin
            item_next.valid     = 1'b1;
            item_next.data_byte = msg.data_byte;
            item_next.last_byte = msg.last_byte;
            item_next.check_crc = msg.check_crc;
        end
        else if (advance)
        begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

### design/crcbs_entry.sv
// ----------------------------------------------------------------------------
// CRC-16 table entry
// Bit-serial table entry for one index byte under the given polynomial.
// ----------------------------------------------------------------------------
module crcbs_entry (
    input  logic [crcbs_pkg::CRC_W-1:0]  polynomial,
    input  logic [crcbs_pkg::DATA_W-1:0] index,
    output logic [crcbs_pkg::CRC_W-1:0]  entry
);

    always_comb
    begin
        logic [crcbs_pkg::CRC_W-1:0] acc;
        logic                        feedback;
        acc = '0;
        // index walked MSB first
        for (int n = crcbs_pkg::DATA_W - 1; n >= 0; n--)
        begin
            feedback = acc[crcbs_pkg::CRC_W-1] ^ index[n];
            acc      = {acc[crcbs_pkg::CRC_W-2:0], 1'b0};
            if (feedback)
            begin
                acc = acc ^ polynomial;
            end
        end
        entry = acc;
    end

endmodule

### design/crcbs_out_reg.sv
// ----------------------------------------------------------------------------
// CRC-16 checker result register
// Holds the final CRC and match flag until the receiver takes them.
// ----------------------------------------------------------------------------
module crcbs_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [crcbs_pkg::CRC_W-1:0] crc,
    input  logic                        match,
    output logic                        free,
    crcbs_result_if.source              result
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [crcbs_pkg::CRC_W-1:0] crc_reg;
    logic                        match_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            crc_reg   <= crc;
            match_reg <= match;
        end
    end

    assign result.valid     = valid_reg;
    assign result.crc_value = crc_reg;
    assign result.crc_match = match_reg;

endmodule

### design/crc16_byte_stream_check.sv
// ----------------------------------------------------------------------------
// CRC-16 byte stream checker
// Running table-form CRC-16 over a byte stream with a match flag per message.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : one item per message byte (data_byte, last_byte, check_crc).
//            check_crc is only looked at on the item with last_byte set.
//   result : one item per message (crc_value, crc_match), after its last byte.
//   cfg    : polynomial write (without its top bit), always ready. Write it
//            only while no byte is held; a change between bytes of a message
//            applies from the next byte without clearing the CRC.
//   Throughput: one byte per cycle when not stalled (see Stall). The CRC
//   update (table entry built from the polynomial in eight shift/xor steps,
//   then shift and xor) sits between the input and running CRC registers.
//   Result path: the last byte goes from the input register into the result
//   register, which holds the CRC and match flag until the receiver takes them.
//   Reset: polynomial returns to 0xA097, running CRC to zero, both item
//   registers empty. No clearing pass.
//   Stall: a held result stops a last byte in the input register and all
//   bytes behind it; earlier bytes keep flowing into the running CRC.
// ----------------------------------------------------------------------------
module crc16_byte_stream_check (
    input  logic           clk,
    input  logic           rst_n,
    crcbs_msg_if.sink      msg,
    crcbs_result_if.source result,
    crcbs_cfg_if.sink      cfg
);

    crcbs_pkg::item_t             item;
    logic                         advance;
    logic                         out_free;
    logic                         out_load;

    logic [crcbs_pkg::CRC_W-1:0]  poly_reg;
    logic [crcbs_pkg::CRC_W-1:0]  poly_next;
    logic [crcbs_pkg::CRC_W-1:0]  crc_reg;
    logic [crcbs_pkg::CRC_W-1:0]  crc_next;
    logic [crcbs_pkg::CRC_W-1:0]  entry;
    logic [crcbs_pkg::CRC_W-1:0]  crc_upd;
    logic                         crc_match;

    // Polynomial register
    assign cfg.ready = 1'b1;

    always_comb
    begin
        poly_next = poly_reg;
        if (cfg.valid)
        begin
            poly_next = cfg.polynomial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= crcbs_pkg::POLY_RESET;
        end
        else
        begin
            poly_reg <= poly_next;
        end
    end

    // A held byte moves on unless it is a last byte facing a full result reg
    assign advance  = item.valid && (!item.last_byte || out_free);
    assign out_load = advance && item.last_byte;

    crcbs_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg),
        .advance (advance),
        .item    (item)
    );

    // Table entry for the current high byte of the running CRC
    crcbs_entry u_entry (
        .polynomial (poly_reg),
        .index      (crc_reg[crcbs_pkg::CRC_W-1 -: crcbs_pkg::DATA_W]),
        .entry      (entry)
    );

    assign crc_upd   = {crc_reg[crcbs_pkg::CRC_W-crcbs_pkg::DATA_W-1:0],
                        {crcbs_pkg::DATA_W{1'b0}}}
                       ^ entry
                       ^ {{(crcbs_pkg::CRC_W-crcbs_pkg::DATA_W){1'b0}}, item.data_byte};
    assign crc_match = (crc_upd == item.check_crc);

    // Running CRC: cleared after the last byte of each message
    always_comb
    begin
        crc_next = crc_reg;
        if (advance)
        begin
            crc_next = item.last_byte ? '0 : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    crcbs_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .crc    (crc_upd),
        .match  (crc_match),
        .free   (out_free),
        .result (result)
    );

endmodule
